// ===== rtl/mte_pkg.sv =====
// Package for the Morse text encoder: symbol codes, code tables and character classifiers.
package mte_pkg;

	// Output symbol codes.
	localparam logic [2:0] SYM_DOT   = 3'd0;
	localparam logic [2:0] SYM_DASH  = 3'd1;
	localparam logic [2:0] SYM_GAP   = 3'd2;
	localparam logic [2:0] SYM_SLASH = 3'd3;
	localparam logic [2:0] SYM_ERR   = 3'd4;
	localparam logic [2:0] SYM_END   = 3'd5;

	// Most symbols that one character can produce.
	localparam int MAX_SYMS = 7;

	// Width of the symbol count.
	localparam int CNT_W = $clog2(MAX_SYMS + 1);

	// Code patterns: the first symbol sits in bit 4, a one is a dash.
	localparam logic [4:0] LETTER_PAT [26] = '{
		5'b01000, 5'b10000, 5'b10100, 5'b10000, 5'b00000, 5'b00100, 5'b11000,
		5'b00000, 5'b00000, 5'b01110, 5'b10100, 5'b01000, 5'b11000, 5'b10000,
		5'b11100, 5'b01100, 5'b11010, 5'b01000, 5'b00000, 5'b10000, 5'b00100,
		5'b00010, 5'b01100, 5'b10010, 5'b10110, 5'b11000
	};

	localparam logic [2:0] LETTER_LEN [26] = '{
		3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3,
		3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2, 3'd2,
		3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3,
		3'd4, 3'd3, 3'd4, 3'd4, 3'd4
	};

	// Digits all take five symbols.
	localparam logic [4:0] DIGIT_PAT [10] = '{
		5'b11111, 5'b01111, 5'b00111, 5'b00011, 5'b00001,
		5'b00000, 5'b10000, 5'b11000, 5'b11100, 5'b11110
	};

	localparam logic [2:0] DIGIT_LEN = 3'd5;

	// Result of a code lookup.
	typedef struct packed {
		logic       hit;
		logic [2:0] len;
		logic [4:0] pat;
	} code_t;

	// Looks up the Morse code of a letter of either case or a digit.
	function automatic code_t code_lookup(input logic [7:0] c);
		code_t      r;
		logic [7:0] up;
		logic [7:0] ofs;
		r   = '0;
		up  = c & 8'hDF;
		ofs = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			ofs   = c - 8'h30;
			r.hit = 1'b1;
			r.len = DIGIT_LEN;
			r.pat = DIGIT_PAT[ofs[3:0]];
		end else if (up >= 8'h41 && up <= 8'h5A) begin
			ofs   = up - 8'h41;
			r.hit = 1'b1;
			r.len = LETTER_LEN[ofs[4:0]];
			r.pat = LETTER_PAT[ofs[4:0]];
		end
		return r;
	endfunction

	// True for the punctuation that adds no code symbols of its own.
	function automatic logic is_punct(input logic [7:0] c);
		return (c == 8'h2C) || (c == 8'h2E) || (c == 8'h3B) || (c == 8'h3A) ||
			(c == 8'h2D) || (c == 8'h21) || (c == 8'h3F) || (c == 8'h27) ||
			(c == 8'h22);
	endfunction

endpackage

// ===== rtl/morse_text_encoder.sv =====
// Morse text encoder: one ASCII character in, a run of Morse symbols out.
// The first symbol of a character is offered in the cycle after the request is taken.
// One symbol per cycle while m_tready is high; a character yields zero to seven symbols.
// The symbol buffer is the limit: a new character enters as its last symbol leaves.
// Reset clears the message state and empties the symbol buffer.
module morse_text_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic       s_tlast,   // message_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [2:0] symbol, [7:3] zero
	output logic       m_tlast    // run_last
);
	import mte_pkg::*;

	// Message state.
	logic seen_text_q, space_pending_q, code_emitted_q;
	logic output_nonempty_q, ended_on_slash_q, error_latched_q;
	logic seen_text_d, space_pending_d, code_emitted_d;
	logic output_nonempty_d, ended_on_slash_d, error_latched_d;

	// Symbol buffer, entry 0 is the one on offer.
	logic [2:0]       sym_q [MAX_SYMS];
	logic [CNT_W-1:0] cnt_q;

	// Symbols of the incoming character.
	logic [2:0]       list_d [MAX_SYMS];
	logic [CNT_W-1:0] n_d;
	code_t            code;
	logic             in_fire, out_fire;

	assign out_fire = m_tvalid && m_tready;
	assign s_tready = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && m_tready);
	assign in_fire  = s_tvalid && s_tready;

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = {5'b0, sym_q[0]};
	assign m_tlast  = (cnt_q == CNT_W'(1));

	assign code = code_lookup(s_tdata);

	// Classify the character, build its symbol list and the next state.
	always_comb begin
		seen_text_d       = seen_text_q;
		space_pending_d   = space_pending_q;
		code_emitted_d    = code_emitted_q;
		output_nonempty_d = output_nonempty_q;
		ended_on_slash_d  = ended_on_slash_q;
		error_latched_d   = error_latched_q;
		for (int i = 0; i < MAX_SYMS; i++) begin
			list_d[i] = SYM_DOT;
		end
		n_d = '0;

		if (!error_latched_q) begin
			if (s_tdata == 8'h20) begin
				if (seen_text_q) begin
					space_pending_d = 1'b1;
				end
			end else if (code.hit || is_punct(s_tdata)) begin
				if (space_pending_q) begin
					list_d[n_d[2:0]]  = SYM_SLASH;
					n_d               = n_d + CNT_W'(1);
					space_pending_d   = 1'b0;
					ended_on_slash_d  = 1'b1;
					output_nonempty_d = 1'b1;
				end
				seen_text_d = 1'b1;
				if (code.hit) begin
					if (code_emitted_q && !ended_on_slash_d) begin
						list_d[n_d[2:0]] = SYM_GAP;
						n_d              = n_d + CNT_W'(1);
					end
					for (int k = 0; k < 5; k++) begin
						if (3'(k) < code.len) begin
							list_d[n_d[2:0]] = code.pat[4-k] ? SYM_DASH : SYM_DOT;
							n_d              = n_d + CNT_W'(1);
						end
					end
					code_emitted_d    = 1'b1;
					output_nonempty_d = 1'b1;
					ended_on_slash_d  = 1'b0;
				end
			end else begin
				list_d[n_d[2:0]] = SYM_ERR;
				n_d              = n_d + CNT_W'(1);
				error_latched_d  = 1'b1;
			end
		end

		// Message end: a trailing word gap if due, then the end marker.
		if (s_tlast) begin
			if (!error_latched_d && space_pending_d && output_nonempty_d &&
					!ended_on_slash_d) begin
				list_d[n_d[2:0]] = SYM_SLASH;
				n_d              = n_d + CNT_W'(1);
			end
			list_d[n_d[2:0]]  = SYM_END;
			n_d               = n_d + CNT_W'(1);
			seen_text_d       = 1'b0;
			space_pending_d   = 1'b0;
			code_emitted_d    = 1'b0;
			output_nonempty_d = 1'b0;
			ended_on_slash_d  = 1'b0;
			error_latched_d   = 1'b0;
		end
	end

	// Message state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_text_q       <= 1'b0;
			space_pending_q   <= 1'b0;
			code_emitted_q    <= 1'b0;
			output_nonempty_q <= 1'b0;
			ended_on_slash_q  <= 1'b0;
			error_latched_q   <= 1'b0;
		end else if (in_fire) begin
			seen_text_q       <= seen_text_d;
			space_pending_q   <= space_pending_d;
			code_emitted_q    <= code_emitted_d;
			output_nonempty_q <= output_nonempty_d;
			ended_on_slash_q  <= ended_on_slash_d;
			error_latched_q   <= error_latched_d;
		end
	end

	// Symbol count: load on a new request, count down as symbols leave.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_fire) begin
			cnt_q <= n_d;
		end else if (out_fire) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Symbol buffer: load a new list or shift toward the output.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < MAX_SYMS; i++) begin
				sym_q[i] <= list_d[i];
			end
		end else if (out_fire) begin
			for (int i = 0; i < MAX_SYMS - 1; i++) begin
				sym_q[i] <= sym_q[i+1];
			end
		end
	end

endmodule
